// File: rtl/mbe_pkg.sv
`timescale 1ns / 1ps

package mbe_pkg;

    // Register and coordinate formats
    localparam int COORD_W = 32;   // Q4.28 configuration words
    localparam int FRAC_W  = 28;
    localparam int Z_W     = 36;   // Q8.28 iteration values
    localparam int M_W     = 30;   // multiplier operand, |z| < 2.0
    localparam int P_W     = 2 * M_W;  // Q4.56 products
    localparam int CNT_W   = 16;
    localparam int IDX_W   = 10;
    localparam int CFG_A_W = 3;

    // Register indexes
    localparam logic [CFG_A_W-1:0] REG_ORIGIN_X = 3'd0;
    localparam logic [CFG_A_W-1:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_A_W-1:0] REG_STEP_X   = 3'd2;
    localparam logic [CFG_A_W-1:0] REG_STEP_Y   = 3'd3;
    localparam logic [CFG_A_W-1:0] REG_MAX_ITER = 3'd4;

    // Products of the complex square unit
    typedef struct packed {
        logic signed [P_W-1:0] xx;
        logic signed [P_W-1:0] yy;
        logic signed [P_W-1:0] xy;
    } t_csq_prod;

endpackage

// File: rtl/mandelbrot_escape_time.sv
`timescale 1ns / 1ps

// Mandelbrot escape-time counter, one pixel per input word.
// Input channel (i_in_valid / o_in_ready) carries a pixel column and row. The
// point c = origin + step * index is formed in Q8.28 with saturation, then
// z = z*z + c is iterated from z = c until |z|^2 >= 4 or the count reaches
// max_iterations. The count leaves on the output channel (o_out_valid /
// i_out_ready) as one word per pixel.
// Configuration words (i_cfg_valid / o_cfg_ready, always ready) write origin,
// step and the iteration limit; indexes above 4 are dropped. Write them only
// while no pixel is in flight.
// Each iteration is a multiply, then the escape test and update, on the single
// complex square unit. One pixel is in flight at a time: o_in_ready is low from
// acceptance until the count is written to the output register, which is
// separate, so a new pixel is taken while the last count waits; a stalled
// receiver only holds the block once a second count is ready. Reset
// (synchronous, active low) restores the default view, -2.0-2.0i with 1/256
// steps and a limit of 256, and empties both channels.
module mandelbrot_escape_time (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // pixel input
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [mbe_pkg::IDX_W-1:0]       i_column,
    input  logic [mbe_pkg::IDX_W-1:0]       i_row,
    // count output
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [mbe_pkg::CNT_W-1:0]       o_iterations,
    // configuration writes
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [mbe_pkg::CFG_A_W-1:0]     i_cfg_index,
    input  logic [mbe_pkg::COORD_W-1:0]     i_cfg_data
);
    import mbe_pkg::*;

    localparam int OFS_W = COORD_W + IDX_W + 1;   // step * index
    localparam int SUM_W = OFS_W + 1;             // origin + step * index
    localparam int UPD_W = P_W - FRAC_W + 1 + 1;  // shifted product + c, with carry

    localparam logic signed [SUM_W-1:0] Z_MAX = SUM_W'((64'sd1 <<< (Z_W - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] Z_MIN = SUM_W'(-(64'sd1 <<< (Z_W - 1)));
    localparam logic signed [Z_W-1:0]   TWO_P = Z_W'(64'sd1 <<< (FRAC_W + 1));
    localparam logic signed [Z_W-1:0]   TWO_N = Z_W'(-(64'sd1 <<< (FRAC_W + 1)));

    typedef enum logic [2:0] {
        S_IDLE,
        S_FORM,
        S_MUL,
        S_UPD,
        S_FINISH
    } t_state;

    t_state                    r_state;
    logic signed [COORD_W-1:0] r_origin_x;
    logic signed [COORD_W-1:0] r_origin_y;
    logic signed [COORD_W-1:0] r_step_x;
    logic signed [COORD_W-1:0] r_step_y;
    logic [CNT_W-1:0]          r_max;

    logic signed [OFS_W-1:0]   r_ofs_x;
    logic signed [OFS_W-1:0]   r_ofs_y;
    logic signed [Z_W-1:0]     r_cx;
    logic signed [Z_W-1:0]     r_cy;
    logic signed [Z_W-1:0]     r_zx;
    logic signed [Z_W-1:0]     r_zy;
    logic [CNT_W-1:0]          r_count;
    logic                      r_out_valid;
    logic [CNT_W-1:0]          r_out_count;

    t_csq_prod                 prod;
    logic                      csq_en;
    logic                      z_small;
    logic [P_W-2:0]            mag2;
    logic signed [P_W:0]       diff;
    logic signed [UPD_W-1:0]   nx_wide;
    logic signed [UPD_W-1:0]   ny_wide;

    function automatic logic signed [Z_W-1:0] sat_z(input logic signed [SUM_W-1:0] v);
        if (v > Z_MAX) begin
            sat_z = Z_MAX[Z_W-1:0];
        end else if (v < Z_MIN) begin
            sat_z = Z_MIN[Z_W-1:0];
        end else begin
            sat_z = v[Z_W-1:0];
        end
    endfunction

    // |x| < 2 and |y| < 2: operands then fit the multiplier
    assign z_small = (r_zx < TWO_P) && (r_zx > TWO_N) && (r_zy < TWO_P) && (r_zy > TWO_N);
    assign csq_en  = (r_state == S_MUL);

    mbe_csq u_csq (
        .i_clk  (i_clk),
        .i_en   (csq_en),
        .i_zx   (r_zx[M_W-1:0]),
        .i_zy   (r_zy[M_W-1:0]),
        .o_prod (prod)
    );

    // Escape test: squares are below 2^58, so the sum reaching 4.0 (2^58 in
    // Q3.56) shows as its top bit.
    assign mag2 = {1'b0, prod.xx[P_W-3:0]} + {1'b0, prod.yy[P_W-3:0]};

    // Floor shift is the arithmetic shift; 2xy drops one bit less.
    assign diff    = (P_W+1)'(prod.xx) - (P_W+1)'(prod.yy);
    assign nx_wide = UPD_W'($signed(diff[P_W:FRAC_W])) + UPD_W'(r_cx);
    assign ny_wide = UPD_W'($signed(prod.xy[P_W-1:FRAC_W-1])) + UPD_W'(r_cy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_origin_x  <= COORD_W'(-32'sd536870912);
            r_origin_y  <= COORD_W'(-32'sd536870912);
            r_step_x    <= COORD_W'(32'sd1048576);
            r_step_y    <= COORD_W'(32'sd1048576);
            r_max       <= CNT_W'(16'd256);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_ORIGIN_X: r_origin_x <= i_cfg_data;
                    REG_ORIGIN_Y: r_origin_y <= i_cfg_data;
                    REG_STEP_X:   r_step_x   <= i_cfg_data;
                    REG_STEP_Y:   r_step_y   <= i_cfg_data;
                    REG_MAX_ITER: r_max      <= i_cfg_data[CNT_W-1:0];
                    default: ;
                endcase
            end

            // in S_FINISH the output register is handled below
            if (r_out_valid && i_out_ready && (r_state != S_FINISH)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_ofs_x <= OFS_W'(r_step_x) * OFS_W'($signed({1'b0, i_column}));
                        r_ofs_y <= OFS_W'(r_step_y) * OFS_W'($signed({1'b0, i_row}));
                        r_state <= S_FORM;
                    end
                end
                S_FORM: begin
                    r_cx    <= sat_z(SUM_W'(r_origin_x) + SUM_W'(r_ofs_x));
                    r_cy    <= sat_z(SUM_W'(r_origin_y) + SUM_W'(r_ofs_y));
                    r_zx    <= sat_z(SUM_W'(r_origin_x) + SUM_W'(r_ofs_x));
                    r_zy    <= sat_z(SUM_W'(r_origin_y) + SUM_W'(r_ofs_y));
                    r_count <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    // limit or large magnitude ends it; else the unit squares z
                    if ((r_count >= r_max) || !z_small) begin
                        r_state <= S_FINISH;
                    end else begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    if (mag2[P_W-2]) begin
                        r_state <= S_FINISH;
                    end else begin
                        r_zx    <= sat_z(SUM_W'(nx_wide));
                        r_zy    <= sat_z(SUM_W'(ny_wide));
                        r_count <= r_count + 1'b1;
                        r_state <= S_MUL;
                    end
                end
                S_FINISH: begin
                    // wait only while an earlier count still sits unread
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_out_count <= r_count;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_iterations = r_out_count;
    assign o_cfg_ready  = 1'b1;

endmodule

// File: rtl/mbe_csq.sv
`timescale 1ns / 1ps

// Shared complex square unit: registers x*x, y*y and x*y of z.
module mbe_csq (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic signed [mbe_pkg::M_W-1:0]   i_zx,
    input  logic signed [mbe_pkg::M_W-1:0]   i_zy,
    output mbe_pkg::t_csq_prod               o_prod
);
    import mbe_pkg::*;

    t_csq_prod r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod.xx <= P_W'(i_zx) * P_W'(i_zx);
            r_prod.yy <= P_W'(i_zy) * P_W'(i_zy);
            r_prod.xy <= P_W'(i_zx) * P_W'(i_zy);
        end
    end

    assign o_prod = r_prod;

endmodule
